// File: rtl/core/lar_pkg.sv
`default_nettype none

package lar_pkg;

  localparam int unsigned CoordW = 6;
  localparam int unsigned CharW  = 8;
  localparam int unsigned GridW  = 7;
  localparam int unsigned ErrW   = 8;

  localparam logic [GridW-1:0] GridSize = 7'd64;

  // Slope thresholds: tan(20 deg) ~ 93/256, tan(70 deg) ~ 703/256.
  localparam logic [9:0] SlopeLow  = 10'd93;
  localparam logic [9:0] SlopeHigh = 10'd703;

  localparam logic [CharW-1:0] ChStar   = 8'h2A;
  localparam logic [CharW-1:0] ChVbar   = 8'h7C;
  localparam logic [CharW-1:0] ChDash   = 8'h2D;
  localparam logic [CharW-1:0] ChBslash = 8'h5C;
  localparam logic [CharW-1:0] ChSlash  = 8'h2F;

  // Register indexes on the configuration port.
  localparam logic RegGridWidth  = 1'b0;
  localparam logic RegGridHeight = 1'b1;

  typedef struct packed {
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
    logic [CoordW-1:0] abs_dx;
    logic [CoordW-1:0] abs_dy;
    logic              step_x_neg;
    logic              step_y_neg;
    logic [CharW-1:0]  ch;
  } cmd_t;

  typedef enum logic {
    WALK_IDLE,
    WALK_RUN
  } walk_state_t;

endpackage

`default_nettype wire

// File: rtl/core/ascii_line_rasterizer_top.sv
`default_nettype none

// Line rasterizer for a character grid. Each request on the input queue is a
// line command (two endpoints, a character and an automatic-character flag);
// the block answers with one point request per Bresenham step, from the first
// endpoint to the second, each carrying its coordinates, the character, an
// inside flag against grid_width/grid_height, and a last marker on the second
// endpoint. A line produces max(|dx|,|dy|)+1 points, at most 64. The walker
// emits one point per cycle while the result side keeps popping, and loads
// each command from the two-entry command queue in its idle state, before
// the first point of the line. The front classifies a command in the cycle it
// is pushed, so up to two commands can wait while a line is still being drawn.
// Registers (APB, 32-bit data): grid_width at 0x0, grid_height at 0x4, both
// 7 bits and resetting to 64. Values above 64 behave as 64, and a value of 0
// flags every point as outside. Write them only while the block is idle.
module ascii_line_rasterizer_top
  import lar_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Command queue side.
  input  wire logic              push,
  output logic                   full,
  input  wire logic [CoordW-1:0] in_start_x,
  input  wire logic [CoordW-1:0] in_start_y,
  input  wire logic [CoordW-1:0] in_end_x,
  input  wire logic [CoordW-1:0] in_end_y,
  input  wire logic              in_auto_char,
  input  wire logic [CharW-1:0]  in_draw_char,
  // Point queue side.
  output logic                   empty,
  input  wire logic              pop,
  output logic [CoordW-1:0]      out_point_x,
  output logic [CoordW-1:0]      out_point_y,
  output logic [CharW-1:0]       out_point_char,
  output logic                   out_inside_res,
  output logic                   out_last,
  // Configuration port.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cmd_t             front_cmd;
  cmd_t             q_data;
  logic             q_empty;
  logic             q_pop;
  logic             out_valid;
  logic [GridW-1:0] grid_width_r, grid_width_nxt;
  logic [GridW-1:0] grid_height_r, grid_height_nxt;
  logic             cfg_wr;
  logic             reg_sel;

  // Configuration registers. The register is picked by the word address;
  // the byte offset within the word is ignored.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    if (cfg_wr) begin
      case (reg_sel)
        RegGridWidth:  grid_width_nxt  = pwdata[GridW-1:0];
        RegGridHeight: grid_height_nxt = pwdata[GridW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GridSize;
      grid_height_r <= GridSize;
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      RegGridWidth:  prdata = {{(32-GridW){1'b0}}, grid_width_r};
      RegGridHeight: prdata = {{(32-GridW){1'b0}}, grid_height_r};
      default:       prdata = '0;
    endcase
  end

  // Front: work out deltas, step directions and the character.
  lar_front u_front (
    .start_x   (in_start_x),
    .start_y   (in_start_y),
    .end_x     (in_end_x),
    .end_y     (in_end_y),
    .auto_char (in_auto_char),
    .draw_char (in_draw_char),
    .cmd       (front_cmd)
  );

  // Short queue between the front and the walker; its full flag is the
  // input side's full.
  lar_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (front_cmd),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // Back: walk the error line one point per cycle, while the output keeps being taken, into an output register.
  lar_walker u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_data      (q_data),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .grid_width  (grid_width_r),
    .grid_height (grid_height_r),
    .point_x     (out_point_x),
    .point_y     (out_point_y),
    .point_char  (out_point_char),
    .inside_res  (out_inside_res),
    .last        (out_last),
    .out_valid   (out_valid),
    .out_take    (pop)
  );

  assign empty = !out_valid;

endmodule

`default_nettype wire

// File: rtl/core/lar_front.sv
`default_nettype none

module lar_front
  import lar_pkg::*;
(
  input  wire logic [CoordW-1:0] start_x,
  input  wire logic [CoordW-1:0] start_y,
  input  wire logic [CoordW-1:0] end_x,
  input  wire logic [CoordW-1:0] end_y,
  input  wire logic              auto_char,
  input  wire logic [CharW-1:0]  draw_char,
  output cmd_t                   cmd
);

  logic              x_fwd;
  logic              y_fwd;
  logic [CoordW-1:0] ax;
  logic [CoordW-1:0] ay;
  logic [15:0]       ay_scaled;
  logic [15:0]       ax_low;
  logic [15:0]       ax_high;
  logic [CharW-1:0]  slope_char;

  assign x_fwd = start_x < end_x;
  assign y_fwd = start_y < end_y;
  assign ax    = x_fwd ? (end_x - start_x) : (start_x - end_x);
  assign ay    = y_fwd ? (end_y - start_y) : (start_y - end_y);

  assign ay_scaled = {2'b00, ay, 8'h00};
  assign ax_low    = {10'd0, ax} * {6'd0, SlopeLow};
  assign ax_high   = {10'd0, ax} * {6'd0, SlopeHigh};

  // Character from the slope; the sign test only matters when both deltas are nonzero.
  always_comb begin
    if (ax == '0 && ay == '0) begin
      slope_char = ChStar;
    end else if (ax == '0) begin
      slope_char = ChVbar;
    end else if (ay == '0) begin
      slope_char = ChDash;
    end else if (ay_scaled < ax_low) begin
      slope_char = ChDash;
    end else if (ay_scaled < ax_high) begin
      slope_char = (x_fwd == y_fwd) ? ChBslash : ChSlash;
    end else begin
      slope_char = ChVbar;
    end
  end

  always_comb begin
    cmd.start_x    = start_x;
    cmd.start_y    = start_y;
    cmd.end_x      = end_x;
    cmd.end_y      = end_y;
    cmd.abs_dx     = ax;
    cmd.abs_dy     = ay;
    cmd.step_x_neg = ~x_fwd;
    cmd.step_y_neg = ~y_fwd;
    cmd.ch         = auto_char ? slope_char : draw_char;
  end

endmodule

`default_nettype wire

// File: rtl/core/lar_cmd_queue.sv
`default_nettype none

module lar_cmd_queue
  import lar_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire cmd_t wr_data,
  output logic      full,
  input  wire logic rd_en,
  output cmd_t      rd_data,
  output logic      empty
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_wr;
  logic       do_rd;

  assign full    = count_r == 2'd2;
  assign empty   = count_r == 2'd0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("command queue count out of range");

endmodule

`default_nettype wire

// File: rtl/core/lar_walker.sv
`default_nettype none

module lar_walker
  import lar_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              q_data,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire logic [GridW-1:0]  grid_width,
  input  wire logic [GridW-1:0]  grid_height,
  output logic [CoordW-1:0]      point_x,
  output logic [CoordW-1:0]      point_y,
  output logic [CharW-1:0]       point_char,
  output logic                   inside_res,
  output logic                   last,
  output logic                   out_valid,
  input  wire logic              out_take
);

  walk_state_t state_r;
  walk_state_t state_nxt;

  logic [CoordW-1:0]     cur_x_r, cur_x_nxt;
  logic [CoordW-1:0]     cur_y_r, cur_y_nxt;
  logic signed [ErrW-1:0] err_r, err_nxt;
  cmd_t                  cmd_r, cmd_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [CoordW-1:0]     pt_x_r, pt_x_nxt;
  logic [CoordW-1:0]     pt_y_r, pt_y_nxt;
  logic [CharW-1:0]      pt_char_r, pt_char_nxt;
  logic                  pt_inside_r, pt_inside_nxt;
  logic                  pt_last_r, pt_last_nxt;

  logic                  slot_free;
  logic                  emit;
  logic                  done;
  logic signed [ErrW:0]  e2;
  logic signed [ErrW:0]  neg_ay;
  logic signed [ErrW:0]  pos_ax;
  logic                  step_x;
  logic                  step_y;
  logic signed [ErrW-1:0] err_dx;
  logic signed [ErrW-1:0] err_dy;

  assign slot_free = !out_valid_r || out_take;
  assign done      = (cur_x_r == cmd_r.end_x) && (cur_y_r == cmd_r.end_y);
  assign e2        = {err_r, 1'b0};
  assign neg_ay    = -$signed({3'b000, cmd_r.abs_dy});
  assign pos_ax    = $signed({3'b000, cmd_r.abs_dx});
  assign step_x    = e2 > neg_ay;
  assign step_y    = e2 < pos_ax;
  assign err_dx    = $signed({2'b00, cmd_r.abs_dx});
  assign err_dy    = $signed({2'b00, cmd_r.abs_dy});

  always_comb begin
    state_nxt     = state_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    err_nxt       = err_r;
    cmd_nxt       = cmd_r;
    q_pop         = 1'b0;
    emit          = 1'b0;
    out_valid_nxt = out_valid_r && !out_take;
    pt_x_nxt      = pt_x_r;
    pt_y_nxt      = pt_y_r;
    pt_char_nxt   = pt_char_r;
    pt_inside_nxt = pt_inside_r;
    pt_last_nxt   = pt_last_r;
    case (state_r)
      WALK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_data;
          cur_x_nxt = q_data.start_x;
          cur_y_nxt = q_data.start_y;
          err_nxt   = $signed({2'b00, q_data.abs_dx}) - $signed({2'b00, q_data.abs_dy});
          state_nxt = WALK_RUN;
        end
      end
      WALK_RUN: begin
        if (slot_free) begin
          emit          = 1'b1;
          out_valid_nxt = 1'b1;
          pt_x_nxt      = cur_x_r;
          pt_y_nxt      = cur_y_r;
          pt_char_nxt   = cmd_r.ch;
          pt_inside_nxt = ({1'b0, cur_x_r} < grid_width) && ({1'b0, cur_y_r} < grid_height);
          pt_last_nxt   = done;
          if (done) begin
            state_nxt = WALK_IDLE;
          end else begin
            err_nxt = err_r - (step_x ? err_dy : '0) + (step_y ? err_dx : '0);
            if (step_x) begin
              cur_x_nxt = cmd_r.step_x_neg ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
            end
            if (step_y) begin
              cur_y_nxt = cmd_r.step_y_neg ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = WALK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= WALK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r     <= cur_x_nxt;
    cur_y_r     <= cur_y_nxt;
    err_r       <= err_nxt;
    cmd_r       <= cmd_nxt;
    pt_x_r      <= pt_x_nxt;
    pt_y_r      <= pt_y_nxt;
    pt_char_r   <= pt_char_nxt;
    pt_inside_r <= pt_inside_nxt;
    pt_last_r   <= pt_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign point_x    = pt_x_r;
  assign point_y    = pt_y_r;
  assign point_char = pt_char_r;
  assign inside_res = pt_inside_r;
  assign last       = pt_last_r;

  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty && state_r == WALK_IDLE)
    else $error("walker took a command from an empty queue or while busy");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && done) |=> state_r == WALK_IDLE && out_valid_r && pt_last_r)
    else $error("final point did not end the line");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_take) |-> !emit)
    else $error("walker overwrote a waiting point");

endmodule

`default_nettype wire

// File: tb/sv/tb_ascii_line_rasterizer_top.sv
module tb_ascii_line_rasterizer_top;
  import lar_pkg::*;

  // One line command as it is pushed into the block.
  typedef struct {
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
    logic              auto_char;
    logic [CharW-1:0]  draw_char;
  } line_cmd_t;

  // One rasterized point as the block should deliver it.
  typedef struct {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CharW-1:0]  ch;
    logic              in_grid;
    logic              last;
  } raster_point_t;

  // The scoreboard keeps its own copy of the grid registers, walks each
  // accepted line the way the block should, and queues the points in order.
  class line_scoreboard;
    raster_point_t pending_points[$];
    logic [GridW-1:0] width_reg;
    logic [GridW-1:0] height_reg;
    int errors;

    function new();
      width_reg = GridSize;
      height_reg = GridSize;
      errors = 0;
    endfunction

    function void set_register(logic idx, logic [GridW-1:0] val);
      if (idx == RegGridWidth) begin
        width_reg = val;
      end else begin
        height_reg = val;
      end
    endfunction

    function int pending_count();
      return pending_points.size();
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      $display("MISMATCH %s: got %0d, wanted %0d", what, got, want);
    endtask

    // Character picked from the slope when the line asks for it. The angle
    // tests against 20 and 70 degrees are done as integer compares.
    function logic [CharW-1:0] slope_char(int dx, int dy);
      int ax;
      int ay;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if (dx == 0 && dy == 0) return ChStar;
      if (dx == 0) return ChVbar;
      if (dy == 0) return ChDash;
      if (256 * ay < int'(SlopeLow) * ax) return ChDash;
      if (256 * ay < int'(SlopeHigh) * ax) return ((dx > 0) == (dy > 0)) ? ChBslash : ChSlash;
      return ChVbar;
    endfunction

    function void note_line(line_cmd_t c);
      int dx;
      int dy;
      int ax;
      int ay;
      int err;
      int e2;
      int gw;
      int gh;
      logic [CoordW-1:0] px;
      logic [CoordW-1:0] py;
      logic [CharW-1:0] ch;
      logic xneg;
      logic yneg;
      raster_point_t p;
      dx = int'(c.end_x) - int'(c.start_x);
      dy = int'(c.end_y) - int'(c.start_y);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      ch = c.auto_char ? slope_char(dx, dy) : c.draw_char;
      xneg = !(c.start_x < c.end_x);
      yneg = !(c.start_y < c.end_y);
      gw = width_reg > GridSize ? int'(GridSize) : int'(width_reg);
      gh = height_reg > GridSize ? int'(GridSize) : int'(height_reg);
      err = ax - ay;
      px = c.start_x;
      py = c.start_y;
      for (int n = 0; n < 64; n++) begin
        p.x = px;
        p.y = py;
        p.ch = ch;
        p.in_grid = (int'(px) < gw) && (int'(py) < gh);
        p.last = (px == c.end_x) && (py == c.end_y);
        pending_points.push_back(p);
        if (p.last) break;
        e2 = 2 * err;
        if (e2 > -ay) begin
          err -= ay;
          px = xneg ? px - 1'b1 : px + 1'b1;
        end
        if (e2 < ax) begin
          err += ax;
          py = yneg ? py - 1'b1 : py + 1'b1;
        end
      end
    endfunction

    task check_point(raster_point_t got);
      raster_point_t want;
      if (pending_points.size() == 0) begin
        report_mismatch("point with no line pending, x", got.x, -1);
      end else begin
        want = pending_points.pop_front();
        if (got.x !== want.x) report_mismatch("point_x", got.x, want.x);
        if (got.y !== want.y) report_mismatch("point_y", got.y, want.y);
        if (got.ch !== want.ch) report_mismatch("point_char", got.ch, want.ch);
        if (got.in_grid !== want.in_grid) begin
          report_mismatch("inside_res", got.in_grid, want.in_grid);
        end
        if (got.last !== want.last) report_mismatch("last", got.last, want.last);
      end
    endtask
  endclass

  // A cycle budget with no request moving in any direction. It is many times
  // the longest honest quiet stretch, a receiver stall or a sender gap, and so
  // many times the slowest correct run.
  localparam int IdleLimit = 4000;

  logic clk = 1'b0;
  logic rst_n;
  logic push;
  logic full;
  logic [CoordW-1:0] in_start_x;
  logic [CoordW-1:0] in_start_y;
  logic [CoordW-1:0] in_end_x;
  logic [CoordW-1:0] in_end_y;
  logic in_auto_char;
  logic [CharW-1:0] in_draw_char;
  logic empty;
  logic pop = 1'b0;
  logic [CoordW-1:0] out_point_x;
  logic [CoordW-1:0] out_point_y;
  logic [CharW-1:0] out_point_char;
  logic out_inside_res;
  logic out_last;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  line_scoreboard board = new();

  // Sender pacing: requests left in the current burst.
  int burst_left = 0;
  // Receiver pacing: the current pop pattern and a stall countdown.
  int pop_mode = 0;
  int pop_hold = 0;
  int pop_cycle = 0;
  int quiet_cycles = 0;

  ascii_line_rasterizer_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_auto_char  (in_auto_char),
    .in_draw_char  (in_draw_char),
    .empty         (empty),
    .pop           (pop),
    .out_point_x   (out_point_x),
    .out_point_y   (out_point_y),
    .out_point_char(out_point_char),
    .out_inside_res(out_inside_res),
    .out_last      (out_last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk = ~clk;

  // The receiver switches between its pop patterns: always
  // ready, a coin toss, one cycle in four, and long stalls now and then.
  // Together they can put a stall on any point of a line, first to last.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop_cycle % 256 == 0) pop_mode = $urandom_range(0, 3);
      pop_cycle++;
      case (pop_mode)
        0: begin
          pop <= 1'b1;
        end
        1: begin
          pop <= 1'($urandom_range(0, 1));
        end
        2: begin
          pop <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          if (pop_hold != 0) begin
            pop_hold--;
            pop <= 1'b0;
          end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 15) == 0) pop_hold = $urandom_range(5, 40);
          end
        end
      endcase
    end
  end

  // Every point request that the block hands over is checked here, at the
  // edge where it is taken. The same process runs the watchdog, which counts
  // cycles in which no request moves on either queue or on the register port.
  always @(posedge clk) begin
    raster_point_t got;
    if (rst_n && pop && !empty) begin
      got.x = out_point_x;
      got.y = out_point_y;
      got.ch = out_point_char;
      got.in_grid = out_inside_res;
      got.last = out_last;
      board.check_point(got);
    end
    if ((push && !full) || (pop && !empty) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("Timeout: no request moved for %0d cycles", IdleLimit);
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one line request and hold it until the block takes it. After
  // that the sender either goes straight on with the next request of the
  // burst, leaving push high, or drops push for a random gap. Most gaps are
  // short; some span most of a long line so that new commands arrive while
  // the walker sits at every stage of its work.
  task automatic issue_line(line_cmd_t c);
    int gap;
    push <= 1'b1;
    in_start_x <= c.start_x;
    in_start_y <= c.start_y;
    in_end_x <= c.end_x;
    in_end_y <= c.end_y;
    in_auto_char <= c.auto_char;
    in_draw_char <= c.draw_char;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_line(c);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 70) : $urandom_range(1, 6);
      burst_left = $urandom_range(0, 10);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Drop push and wait until every point of every accepted line has come
  // back. The registers may only change in that state.
  task automatic drain_lines();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.pending_count() != 0) @(posedge clk);
  endtask

  // Write a grid register with a setup and an access cycle, then read it
  // back. The upper data bits carry noise; only seven bits are stored.
  task automatic write_grid_reg(logic idx, logic [GridW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {25'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_register(idx, val);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {25'd0, val}) board.report_mismatch("register read back", prdata, val);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [CoordW-1:0] nearby(logic [CoordW-1:0] v);
    int t;
    t = int'(v) + $urandom_range(0, 8) - 4;
    if (t < 0) t = 0;
    if (t > 63) t = 63;
    return CoordW'(t);
  endfunction

  function automatic line_cmd_t line_of(int sx, int sy, int ex, int ey, bit auto_sel, int ch);
    line_cmd_t c;
    c.start_x = CoordW'(sx);
    c.start_y = CoordW'(sy);
    c.end_x = CoordW'(ex);
    c.end_y = CoordW'(ey);
    c.auto_char = auto_sel;
    c.draw_char = CharW'(ch);
    return c;
  endfunction

  // Random lines: a share of single points, straight lines and short lines,
  // and the rest with both endpoints anywhere on the grid.
  function automatic line_cmd_t random_line();
    line_cmd_t c;
    int kind;
    kind = $urandom_range(0, 9);
    c.start_x = CoordW'($urandom_range(0, 63));
    c.start_y = CoordW'($urandom_range(0, 63));
    c.end_x = CoordW'($urandom_range(0, 63));
    c.end_y = CoordW'($urandom_range(0, 63));
    c.auto_char = 1'($urandom_range(0, 1));
    c.draw_char = CharW'($urandom_range(0, 255));
    case (kind)
      0: begin
        c.end_x = c.start_x;
        c.end_y = c.start_y;
      end
      1: begin
        c.end_y = c.start_y;
      end
      2: begin
        c.end_x = c.start_x;
      end
      3, 4: begin
        c.end_x = nearby(c.start_x);
        c.end_y = nearby(c.start_y);
      end
      default: begin
      end
    endcase
    return c;
  endfunction

  // Grid settings for the random phases: each side zero, the smallest grid,
  // values past the grid size that must act as full size, odd sizes, and
  // finally the reset value again.
  int phase_width[8] = '{0, 64, 1, 127, 65, 63, 37, 64};
  int phase_height[8] = '{64, 0, 1, 127, 100, 1, 50, 64};

  initial begin
    rst_n <= 1'b0;
    push <= 1'b0;
    in_start_x <= '0;
    in_start_y <= '0;
    in_end_x <= '0;
    in_end_y <= '0;
    in_auto_char <= 1'b0;
    in_draw_char <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines under the reset grid. They cover a single point at both
    // corners, full-length horizontal and vertical lines in both directions,
    // the four diagonals, both sides of the 70 degree slope threshold for each sign,
    // both sides of the 20 degree one for one sign, and given byte-extreme characters.
    issue_line(line_of(0, 0, 0, 0, 1, 8'h00));
    issue_line(line_of(63, 63, 63, 63, 0, 8'hFF));
    issue_line(line_of(0, 0, 63, 0, 1, 8'h41));
    issue_line(line_of(63, 5, 0, 5, 0, 8'h00));
    issue_line(line_of(10, 0, 10, 63, 1, 8'h00));
    issue_line(line_of(20, 63, 20, 0, 1, 8'hFF));
    issue_line(line_of(0, 0, 63, 63, 1, 8'h00));
    issue_line(line_of(63, 0, 0, 63, 1, 8'h00));
    issue_line(line_of(0, 63, 63, 0, 1, 8'h00));
    issue_line(line_of(63, 63, 0, 0, 1, 8'h00));
    issue_line(line_of(0, 0, 63, 22, 1, 8'h00));
    issue_line(line_of(0, 0, 63, 23, 1, 8'h00));
    issue_line(line_of(63, 40, 0, 18, 1, 8'h00));
    issue_line(line_of(0, 0, 10, 27, 1, 8'h00));
    issue_line(line_of(0, 0, 10, 28, 1, 8'h00));
    issue_line(line_of(40, 30, 30, 57, 1, 8'h00));
    issue_line(line_of(40, 30, 30, 58, 1, 8'h00));
    issue_line(line_of(5, 9, 6, 63, 1, 8'h00));
    issue_line(line_of(21, 42, 42, 21, 0, 8'hA5));
    issue_line(line_of(1, 2, 62, 61, 0, 8'h5A));
    drain_lines();

    // Each phase waits for the block to go idle, sets both grid registers,
    // and sends a stream of random lines. The drain before each write is
    // also the point where the sender holds off until every point is back.
    for (int ph = 0; ph < 8; ph++) begin
      write_grid_reg(RegGridWidth, GridW'(phase_width[ph]));
      write_grid_reg(RegGridHeight, GridW'(phase_height[ph]));
      @(posedge clk);
      issue_line(line_of(0, 0, 1, 1, 1, 8'h00));
      repeat (12) issue_line(random_line());
      drain_lines();
    end

    // Give a stray point a line's worth of cycles to show up.
    repeat (80) @(posedge clk);
    if (board.pending_count() != 0) begin
      board.report_mismatch("points never delivered", 0, board.pending_count());
    end
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
